@@ rtl/mcr_pkg.sv @@
// Shared types and constants of the Moravec corner response block.
// No dependencies; imported by every rtl module.
package mcr_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 11;
  localparam int RESP_W     = 20;
  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int WIN_N      = 5;
  localparam int N_SHIFT    = 4;
  localparam int N_TAP      = 9;
  localparam int QDEPTH     = 4;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [RESP_W-1:0] CAP_RST    = 20'd15000;

  // shifts: right, left, down, up
  localparam int SHIFT_DY [N_SHIFT] = '{0, 0, 1, -1};
  localparam int SHIFT_DX [N_SHIFT] = '{1, -1, 0, 0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_CAP    = 2'd2
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] column_t;  // [0] oldest row, [4] incoming pixel

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  typedef struct packed {
    column_t column;
    logic    emit;
    coord_t  coord;
  } item_t;

endpackage

@@ rtl/mcr_front.sv @@
// Front end: request intake, raster counters, line store and column build.
// Depends on mcr_pkg; pushes one column item per request into mcr_fifo.
module mcr_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pixel_valid_i,
  output logic                  pixel_ready_o,
  input  logic [mcr_pkg::PIX_W-1:0] pixel_i,
  input  logic [mcr_pkg::DIM_W-1:0] width_i,
  input  logic [mcr_pkg::DIM_W-1:0] height_i,
  input  logic                  full_i,
  output logic                  push_o,
  output mcr_pkg::item_t        item_o
);
  import mcr_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CCMPW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int RCMPW = (RW + 1 > DIM_W) ? RW + 1 : DIM_W;
  localparam int CXW   = (CW > COORD_W) ? CW : COORD_W;
  localparam int RXW   = (RW > COORD_W) ? RW : COORD_W;
  localparam int WORD_W = (WIN_N - 1) * PIX_W;

  logic [WORD_W-1:0] mem [MAX_WIDTH];

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic              f1_v_q, f1_v_d;
  pix_t              f1_pix_q;
  logic [CW-1:0]     f1_addr_q;
  logic              f1_emit_q;
  coord_t            f1_coord_q;
  logic [WORD_W-1:0] rd_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic              accept;
  logic              push;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] wr_word;
  logic [CCMPW-1:0]  w_cfg, w_lim, col_nxt;
  logic [RCMPW-1:0]  h_cfg, h_lim, row_nxt;
  logic [CXW-1:0]    col_ctr;
  logic [RXW-1:0]    row_ctr;
  logic              emit;
  coord_t            coord;

  assign push          = f1_v_q & ~full_i;
  assign pixel_ready_o = ~f1_v_q | ~full_i;
  assign accept        = pixel_valid_i & pixel_ready_o;

  assign old_word = fwd_q ? fwd_data_q : rd_q;
  assign wr_word  = {f1_pix_q, old_word[WORD_W-1:PIX_W]};

  assign push_o        = push;
  assign item_o.column = column_t'({f1_pix_q, old_word});
  assign item_o.emit   = f1_emit_q;
  assign item_o.coord  = f1_coord_q;

  always_comb begin
    w_cfg = CCMPW'(width_i);
    w_lim = (w_cfg > CCMPW'(MAX_WIDTH)) ? CCMPW'(MAX_WIDTH) : w_cfg;
    if (w_lim == '0) begin
      w_lim = CCMPW'(1);
    end
    h_cfg = RCMPW'(height_i);
    h_lim = (h_cfg > RCMPW'(MAX_HEIGHT)) ? RCMPW'(MAX_HEIGHT) : h_cfg;
    if (h_lim == '0) begin
      h_lim = RCMPW'(1);
    end
    col_nxt = CCMPW'(col_q) + CCMPW'(1);
    row_nxt = RCMPW'(row_q) + RCMPW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_nxt >= w_lim) begin
        col_d = '0;
        row_d = (row_nxt >= h_lim) ? '0 : row_nxt[RW-1:0];
      end else begin
        col_d = col_nxt[CW-1:0];
      end
    end
  end

  always_comb begin
    col_ctr   = CXW'(col_q) - CXW'(2);
    row_ctr   = RXW'(row_q) - RXW'(2);
    emit      = (RXW'(row_q) >= RXW'(4)) && (CXW'(col_q) >= CXW'(4));
    coord.row = row_ctr[COORD_W-1:0];
    coord.col = col_ctr[COORD_W-1:0];
  end

  always_comb begin
    f1_v_d = f1_v_q;
    if (accept) begin
      f1_v_d = 1'b1;
    end else if (push) begin
      f1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      f1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      f1_v_q <= f1_v_d;
      if (accept) begin
        fwd_q <= push && (f1_addr_q == col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_pix_q   <= pixel_i;
      f1_addr_q  <= col_q;
      f1_emit_q  <= emit;
      f1_coord_q <= coord;
      fwd_data_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[f1_addr_q] <= wr_word;
    end
    if (accept) begin
      rd_q <= mem[col_q];
    end
  end

endmodule

@@ rtl/mcr_fifo.sv @@
// Short queue of column items between the front end and the score pipeline.
// Depends on mcr_pkg for the item type and depth.
module mcr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mcr_pkg::item_t item_o
);
  import mcr_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int NW = $clog2(QDEPTH + 1);

  item_t          buf_q [QDEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == NW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = buf_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + NW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue pop while empty");

endmodule

@@ rtl/mcr_back.sv @@
// Back end: 5x5 window, four shifted SSD sums, min and cap, result register.
// Depends on mcr_pkg; pops column items from mcr_fifo.
module mcr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  mcr_pkg::item_t              item_i,
  output logic                        pop_o,
  input  logic [mcr_pkg::RESP_W-1:0]  cap_i,
  output logic                        result_valid_o,
  input  logic                        result_ready_i,
  output logic [mcr_pkg::COORD_W-1:0] center_row_o,
  output logic [mcr_pkg::COORD_W-1:0] center_col_o,
  output logic [mcr_pkg::RESP_W-1:0]  response_o,
  output logic                        corner_o
);
  import mcr_pkg::*;

  localparam int SQ_W = 2 * PIX_W;
  localparam int RS_W = SQ_W + 2;

  pix_t win_q [WIN_N][WIN_N];

  logic   s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  coord_t s0_c_q, s1_c_q, s2_c_q, s3_c_q, s4_c_q;

  logic [PIX_W-1:0]  d_d   [N_SHIFT][N_TAP];
  logic [PIX_W-1:0]  d_q   [N_SHIFT][N_TAP];
  logic [SQ_W-1:0]   sq_d  [N_SHIFT][N_TAP];
  logic [SQ_W-1:0]   sq_q  [N_SHIFT][N_TAP];
  logic [RS_W-1:0]   rs_d  [N_SHIFT][3];
  logic [RS_W-1:0]   rs_q  [N_SHIFT][3];
  logic [RESP_W-1:0] sum_d [N_SHIFT];
  logic [RESP_W-1:0] sum_q [N_SHIFT];

  logic [RESP_W-1:0] mn01, mn23, mn, best;
  logic              adv, pop;

  assign adv   = ~out_v_q | result_ready_i;
  assign pop   = adv & ~empty_i;
  assign pop_o = pop;

  always_comb begin
    pix_t a;
    pix_t b;
    a = '0;
    b = '0;
    for (int s = 0; s < N_SHIFT; s++) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          a = win_q[1 + j][1 + i];
          b = win_q[1 + j + SHIFT_DY[s]][1 + i + SHIFT_DX[s]];
          d_d[s][3 * j + i] = (a > b) ? a - b : b - a;
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < N_SHIFT; s++) begin
      for (int t = 0; t < N_TAP; t++) begin
        sq_d[s][t] = SQ_W'(d_q[s][t]) * SQ_W'(d_q[s][t]);
      end
      for (int j = 0; j < 3; j++) begin
        rs_d[s][j] = RS_W'(sq_q[s][3 * j]) + RS_W'(sq_q[s][3 * j + 1])
                   + RS_W'(sq_q[s][3 * j + 2]);
      end
      sum_d[s] = RESP_W'(rs_q[s][0]) + RESP_W'(rs_q[s][1]) + RESP_W'(rs_q[s][2]);
    end
  end

  always_comb begin
    mn01 = (sum_q[1] < sum_q[0]) ? sum_q[1] : sum_q[0];
    mn23 = (sum_q[3] < sum_q[2]) ? sum_q[3] : sum_q[2];
    mn   = (mn23 < mn01) ? mn23 : mn01;
    best = (mn < cap_i) ? mn : cap_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q  <= pop & item_i.emit;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int k = 0; k < WIN_N; k++) begin
        for (int j = 0; j < WIN_N - 1; j++) begin
          win_q[k][j] <= win_q[k][j + 1];
        end
        win_q[k][WIN_N - 1] <= item_i.column[k];
      end
      s0_c_q <= item_i.coord;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q    <= d_d;
      sq_q   <= sq_d;
      rs_q   <= rs_d;
      sum_q  <= sum_d;
      s1_c_q <= s0_c_q;
      s2_c_q <= s1_c_q;
      s3_c_q <= s2_c_q;
      s4_c_q <= s3_c_q;
      if (s4_v_q) begin
        center_row_o <= s4_c_q.row;
        center_col_o <= s4_c_q.col;
        response_o   <= best;
        corner_o     <= (best >= cap_i);
      end
    end
  end

  assign result_valid_o = out_v_q;

  a_resp_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (response_o <= cap_i)) else $error("response above cap");

  a_corner_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (corner_o == (response_o == cap_i)))
    else $error("corner flag disagrees with response");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && adv) |=> result_valid_o) else $error("scored pixel dropped");

endmodule

@@ rtl/moravec_corner_response.sv @@
// Moravec corner response, top level: configuration registers and wiring.
// Depends on mcr_pkg, mcr_front, mcr_fifo and mcr_back.
//
// Pixels enter in raster order, one request per clock at full rate. While a result
// waits on the output, the block takes up to five more pixels into its front stage
// and a four-entry queue, then stalls the input. Four previous rows live in a simple
// dual-port line store (one read and one write of a 32-bit word per pixel, with a
// bypass when consecutive pixels share a column), so the sustained rate is one pixel
// per cycle. With the output free, an accepted pixel passes the front stage, queue,
// window and difference, square, row-sum and sum registers to the result register.
// Pixels whose centre lies within two pixels of the border give no result. Configure
// only while the block is idle; the line store needs no clearing after reset.
module moravec_corner_response #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mcr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            pixel_valid_i,
  output logic                            pixel_ready_o,
  input  logic [mcr_pkg::PIX_W-1:0]       pixel_i,
  output logic                            result_valid_o,
  input  logic                            result_ready_i,
  output logic [mcr_pkg::COORD_W-1:0]     center_row_o,
  output logic [mcr_pkg::COORD_W-1:0]     center_col_o,
  output logic [mcr_pkg::RESP_W-1:0]      response_o,
  output logic                            corner_o
);
  import mcr_pkg::*;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [RESP_W-1:0] cap_q;

  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      cap_q    <= CAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_CAP:    cap_q    <= cfg_wdata_i[RESP_W-1:0];
        default: ;
      endcase
    end
  end

  mcr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .width_i       (width_q),
    .height_i      (height_q),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  mcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  mcr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .item_i         (pop_item),
    .pop_o          (pop),
    .cap_i          (cap_q),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .center_row_o   (center_row_o),
    .center_col_o   (center_col_o),
    .response_o     (response_o),
    .corner_o       (corner_o)
  );

endmodule
